// File: sv/sorted_sequence_reorder_buffer_macros.svh
`ifndef SORTED_SEQUENCE_REORDER_BUFFER_MACROS_SVH
`define SORTED_SEQUENCE_REORDER_BUFFER_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SSRB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSRB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ssrb_pkg.sv
package ssrb_pkg;

   localparam int DEPTH    = 64;
   localparam int TAG_BITS = 16;
   localparam int SEQ_BITS = 32;
   localparam int DUP_BITS = 32;
   localparam int OCC_BITS = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_CMP  = 1'b1
   } state_type;

   typedef struct packed {
      logic                       valid;
      logic signed [SEQ_BITS-1:0] seq;
      logic [TAG_BITS-1:0]        tag;
   } cell_data_type;

   // broadcast to every cell in the chain
   typedef struct packed {
      logic                       cmp_en;
      logic signed [SEQ_BITS-1:0] cmp_seq;
      logic                       ins_en;
      logic signed [SEQ_BITS-1:0] ins_seq;
      logic [TAG_BITS-1:0]        ins_tag;
      logic                       pop_en;
   } cell_ctrl_type;

endpackage

// File: sv/ssrb_req_if.sv
interface ssrb_req_if import ssrb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 operation;
   logic signed [SEQ_BITS-1:0] seq_num;
   logic [TAG_BITS-1:0]        packet_tag;

   modport source (output valid, operation, seq_num, packet_tag, input ready);
   modport sink   (input valid, operation, seq_num, packet_tag, output ready);
endinterface

// File: sv/ssrb_rsp_if.sv
interface ssrb_rsp_if import ssrb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [2:0]                 status;
   logic [TAG_BITS-1:0]        tag_out;
   logic signed [SEQ_BITS-1:0] seq_out;
   logic [OCC_BITS-1:0]        occupancy;
   logic [DUP_BITS-1:0]        duplicate_count;

   modport source (output valid, status, tag_out, seq_out, occupancy, duplicate_count,
                   input ready);
   modport sink   (input valid, status, tag_out, seq_out, occupancy, duplicate_count,
                   output ready);
endinterface

// File: sv/sorted_sequence_reorder_buffer.sv
// Flow: the cells latch the compare at the request edge; the shift and the result register follow
//   at the commit edge, which waits while the result register is held by back-pressure.
// A new request is taken only in S_IDLE, once the compare-then-shift pass of the cell chain for
//   the last one has committed.
// Reset (synchronous, active high): clears the cell valid bits, occupancy and duplicate count;
//   stored sequence numbers and tags are left as they were. No clearing pass.
module sorted_sequence_reorder_buffer import ssrb_pkg::*; (
   input logic        clock,
   input logic        reset,
   ssrb_req_if.sink   req_bus,
   ssrb_rsp_if.source rsp_bus
);

   state_type state_ff, state_in;

   op_type                     op_ff;
   logic signed [SEQ_BITS-1:0] seq_ff;
   logic [TAG_BITS-1:0]        tag_ff;

   logic [OCC_BITS-1:0] count_ff, count_in;
   logic [DUP_BITS-1:0] dup_ff, dup_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]        rsp_tag_ff, rsp_tag_in;
   logic signed [SEQ_BITS-1:0] rsp_seq_ff, rsp_seq_in;

   logic accept, commit;

   cell_ctrl_type ctrl;
   cell_data_type cell_data [DEPTH];
   cell_data_type cell_hit  [DEPTH];
   logic          cell_lt   [DEPTH];
   logic [DEPTH-1:0] cell_match;

   cell_data_type hit_all;
   logic          any_match;
   logic          full;

   // ---- control ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_CMP;
         S_CMP:   if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = (state_ff == S_IDLE);
      commit        = (state_ff == S_CMP) && (!rsp_valid_ff || rsp_bus.ready);
   end

   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         op_ff  <= op_type'(req_bus.operation);
         seq_ff <= req_bus.seq_num;
         tag_ff <= req_bus.packet_tag;
      end
   end

   // ---- cell chain ----
   always_comb begin
      hit_all = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit_all = hit_all | cell_hit[i];
      end
   end

   assign any_match = |cell_match;
   assign full      = cell_data[DEPTH-1].valid;

   always_comb begin
      count_in      = count_ff;
      dup_in        = dup_ff;
      rsp_status_in = ST_OK;
      rsp_tag_in    = '0;
      rsp_seq_in    = '0;
      ctrl.cmp_en   = accept;
      ctrl.cmp_seq  = req_bus.seq_num;
      ctrl.ins_en   = 1'b0;
      ctrl.ins_seq  = seq_ff;
      ctrl.ins_tag  = tag_ff;
      ctrl.pop_en   = 1'b0;
      if (commit) begin
         case (op_ff)
            OP_INSERT: begin
               if (any_match) begin
                  rsp_status_in = ST_DUP;
                  dup_in        = dup_ff + DUP_BITS'(1);
               end else if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  ctrl.ins_en = 1'b1;
                  count_in    = count_ff + OCC_BITS'(1);
               end
            end
            OP_POP: begin
               if (!cell_data[0].valid) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  ctrl.pop_en = 1'b1;
                  rsp_tag_in  = cell_data[0].tag;
                  rsp_seq_in  = cell_data[0].seq;
                  count_in    = count_ff - OCC_BITS'(1);
               end
            end
            OP_LOOKUP: begin
               if (any_match) begin
                  rsp_tag_in = hit_all.tag;
                  rsp_seq_in = hit_all.seq;
               end else begin
                  rsp_status_in = ST_NOTFOUND;
               end
            end
            default: rsp_status_in = ST_OK;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         cell_data_type left_d, right_d;
         logic          left_l;
         if (g == 0) begin : g_head
            assign left_d = '0;
            assign left_l = 1'b1;
         end else begin : g_body
            assign left_d = cell_data[g-1];
            assign left_l = cell_lt[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign right_d = '0;
         end else begin : g_next
            assign right_d = cell_data[g+1];
         end
         ssrb_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .left_lt    (left_l),
            .right_data (right_d),
            .data       (cell_data[g]),
            .lt         (cell_lt[g]),
            .match      (cell_match[g]),
            .hit        (cell_hit[g])
         );
      end
   endgenerate

   // ---- result register ----
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         dup_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         dup_ff       <= dup_in;
      end
      if (commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_tag_ff    <= rsp_tag_in;
         rsp_seq_ff    <= rsp_seq_in;
      end
   end

   // occupancy and duplicate count track the step just committed
   logic [OCC_BITS-1:0] rsp_occ_ff;
   logic [DUP_BITS-1:0] rsp_dup_ff;

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_occ_ff <= count_in;
         rsp_dup_ff <= dup_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.status          = rsp_status_ff;
   assign rsp_bus.tag_out         = rsp_tag_ff;
   assign rsp_bus.seq_out         = rsp_seq_ff;
   assign rsp_bus.occupancy       = rsp_occ_ff;
   assign rsp_bus.duplicate_count = rsp_dup_ff;

endmodule

// File: sv/ssrb_cell.sv
module ssrb_cell import ssrb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_data_type left_data,
   input  logic          left_lt,
   input  cell_data_type right_data,
   output cell_data_type data,
   output logic          lt,
   output logic          match,
   output cell_data_type hit
);

   cell_data_type data_ff, data_in;
   logic          lt_ff, lt_in;
   logic          match_ff, match_in;

   always_comb begin
      data_in  = data_ff;
      lt_in    = lt_ff;
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = data_ff.valid && (data_ff.seq == ctrl.cmp_seq);
         lt_in    = data_ff.valid && ($signed(data_ff.seq) < $signed(ctrl.cmp_seq));
      end
      if (ctrl.ins_en) begin
         // entries below the key stay; the first cell past them takes the new one
         if (!lt_ff) begin
            if (left_lt) begin
               data_in.valid = 1'b1;
               data_in.seq   = ctrl.ins_seq;
               data_in.tag   = ctrl.ins_tag;
            end else begin
               data_in = left_data;
            end
         end
      end else if (ctrl.pop_en) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
      lt_ff    <= lt_in;
      match_ff <= match_in;
   end

   assign data  = data_ff;
   assign lt    = lt_ff;
   assign match = match_ff;
   assign hit   = match_ff ? data_ff : '0;

endmodule

// File: sv/ssrb_checker.sv
`include "sorted_sequence_reorder_buffer_macros.svh"

module ssrb_checker import ssrb_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_status,
   input logic [TAG_BITS-1:0]        rsp_tag_out,
   input logic signed [SEQ_BITS-1:0] rsp_seq_out,
   input logic [OCC_BITS-1:0]        rsp_occupancy
);

   `SSRB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seq_out) && $stable(rsp_tag_out), "result beat changed while stalled")

   // error results carry no entry
   `SSRB_ASSERT_NOW(a_err_zero, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY || rsp_status == ST_NOTFOUND || rsp_status == ST_DUP), rsp_tag_out == '0 && rsp_seq_out == '0, "error result carries data")

   `SSRB_ASSERT_NOW(a_full_occ, rsp_valid && rsp_status == ST_FULL, rsp_occupancy == OCC_BITS'(DEPTH), "full reported below capacity")

   `SSRB_ASSERT_NOW(a_empty_occ, rsp_valid && rsp_status == ST_EMPTY, rsp_occupancy == '0, "empty reported with entries held")

   `SSRB_ASSERT_NOW(a_occ_range, rsp_valid, rsp_occupancy <= OCC_BITS'(DEPTH), "occupancy above capacity")

endmodule

bind sorted_sequence_reorder_buffer ssrb_checker u_ssrb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_status    (rsp_bus.status),
   .rsp_tag_out   (rsp_bus.tag_out),
   .rsp_seq_out   (rsp_bus.seq_out),
   .rsp_occupancy (rsp_bus.occupancy)
);
